[hw/rtl/wqbd_pkg.sv]
// shared types, codes and burst size selection for the write queue burst drain
`timescale 1ns / 1ps
`default_nettype none

package wqbd_pkg;

	typedef enum logic [1:0] {
		CMD_SETUP = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_DRAIN = 2'd2
	} wqbd_cmd_code_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SCAN  = 2'd1,
		ST_FETCH = 2'd2,
		ST_PUT   = 2'd3
	} wqbd_state_t;

	// controller to datapath
	typedef struct packed {
		logic setup;
		logic push;
		logic scan;
		logic fetch;
		logic put;
	} wqbd_ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic found;
		logic lane_last;
		logic word_full;
		logic out_free;
		logic word_last;
	} wqbd_status_t;

	localparam logic [5:0] BURST_MAX  = 6'd32;
	localparam logic [2:0] LANES_WORD = 3'd4;
	localparam logic [2:0] CODE_WORD  = 3'd2;

	// largest power-of-two burst the address is aligned to and the count covers
	function automatic logic [2:0] pick_size_code(input logic [4:0] addr_lo,
			input logic [5:0] cnt);
		logic [2:0] code;
		if (addr_lo[4:0] == 5'd0 && cnt >= 6'd32) begin
			code = 3'd5;
		end else if (addr_lo[3:0] == 4'd0 && cnt >= 6'd16) begin
			code = 3'd4;
		end else if (addr_lo[2:0] == 3'd0 && cnt >= 6'd8) begin
			code = 3'd3;
		end else if (addr_lo[1:0] == 2'd0 && cnt >= 6'd4) begin
			code = 3'd2;
		end else if (addr_lo[0] == 1'b0 && cnt >= 6'd2) begin
			code = 3'd1;
		end else begin
			code = 3'd0;
		end
		return code;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/wqbd_ctrl.sv]
// controller state machine: command decode, scan, byte fetch and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module wqbd_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire  [1:0]            command,
	output logic                  in_stall,
	output wqbd_pkg::wqbd_ctrl_t   ctrl,
	input  wqbd_pkg::wqbd_status_t status
);
	import wqbd_pkg::*;

	wqbd_state_t state_q;
	wqbd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (wqbd_cmd_code_t'(command))
						CMD_SETUP: ctrl.setup = 1'b1;
						CMD_PUSH:  ctrl.push = 1'b1;
						CMD_DRAIN: state_d = ST_SCAN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				ctrl.scan = 1'b1;
				state_d   = status.found ? ST_FETCH : ST_PUT;
			end
			ST_FETCH: begin
				ctrl.fetch = 1'b1;
				if (status.lane_last) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				ctrl.put = 1'b1;
				if (status.word_full && status.out_free) begin
					state_d = status.word_last ? ST_IDLE : ST_FETCH;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/wqbd_dp.sv]
// datapath: queue registers, byte ring memory, burst assembly and output register
`timescale 1ns / 1ps
`default_nettype none

module wqbd_dp #(
	parameter int NUM_QUEUES  = 4,
	parameter int QUEUE_BYTES = 64
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wqbd_pkg::wqbd_ctrl_t    ctrl,
	output wqbd_pkg::wqbd_status_t  status,
	input  wire                    cfg_wr_en,
	input  wire                    array_configured,
	input  wire  [1:0]             queue_index,
	input  wire  [31:0]            start_address,
	input  wire                    queue_enable,
	input  wire                    is_write,
	input  wire  [3:0]             attributes,
	input  wire  [7:0]             data_byte,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic                   request_valid,
	output logic [1:0]             served_queue,
	output logic [31:0]            request_address,
	output logic [2:0]             size_code,
	output logic [3:0]             request_attributes,
	output logic [31:0]            data_word,
	output logic                   last
);
	import wqbd_pkg::*;

	localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int OW        = $clog2(QUEUE_BYTES);
	localparam int CW        = $clog2(QUEUE_BYTES + 1);
	localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_BYTES;
	localparam int MAW       = $clog2(MEM_DEPTH);

	// queue state
	logic [31:0]   qaddr_q [NUM_QUEUES];
	logic [CW-1:0] qcount_q [NUM_QUEUES];
	logic [OW-1:0] rdoff_q [NUM_QUEUES];
	logic [OW-1:0] wroff_q [NUM_QUEUES];
	logic          qon_q [NUM_QUEUES];
	logic          qwr_q [NUM_QUEUES];
	logic [3:0]    qattr_q [NUM_QUEUES];
	logic          cfg_q;

	logic [7:0]    mem_q [MEM_DEPTH];
	logic [7:0]    rd_data_s1;
	logic          rd_vld_s1;
	logic [1:0]    rd_lane_s1;
	logic          rd_fin_s1;

	// burst in progress
	logic [QW-1:0] bq_q;
	logic          bvalid_q;
	logic [31:0]   baddr_q;
	logic [2:0]    bcode_q;
	logic [3:0]    battr_q;
	logic [OW-1:0] boff_q;
	logic [5:0]    byte_cnt_q;
	logic [31:0]   word_q;
	logic          word_full_q;
	logic          word_last_q;

	logic          out_valid_q;
	logic          o_req_valid_q;
	logic [1:0]    o_queue_q;
	logic [31:0]   o_addr_q;
	logic [2:0]    o_code_q;
	logic [3:0]    o_attr_q;
	logic [31:0]   o_data_q;
	logic          o_last_q;

	logic [NUM_QUEUES-1:0] elig;
	logic                  found;
	logic [QW-1:0]         sel;
	logic [5:0]            cnt_sat;
	logic [2:0]            new_code;
	logic [5:0]            new_nbytes;
	logic [OW:0]           rd_adv_sum;
	logic [OW-1:0]         rd_adv;
	logic [5:0]            b_nbytes;
	logic [2:0]            lanes;
	logic                  lane_last;
	logic [OW:0]           ring_sum;
	logic [OW-1:0]         ring_idx;
	logic [MAW-1:0]        rd_addr;
	logic                  qi_hit;
	logic [OW-1:0]         wr_off_sel;
	logic [CW-1:0]         wr_cnt_sel;
	logic                  push_ok;
	logic [MAW-1:0]        wr_addr;
	logic                  out_free;
	logic                  load_out;

	// priority scan and burst sizing
	always_comb begin
		elig = '0;
		sel  = '0;
		for (int k = 0; k < NUM_QUEUES; k++) begin
			elig[k] = cfg_q && qon_q[k] && qwr_q[k] && (qcount_q[k] != '0);
		end
		for (int k = NUM_QUEUES - 1; k >= 0; k--) begin
			if (elig[k]) begin
				sel = QW'(k);
			end
		end
		found      = |elig;
		cnt_sat    = (qcount_q[sel] >= CW'(BURST_MAX)) ? BURST_MAX : qcount_q[sel][5:0];
		new_code   = pick_size_code(qaddr_q[sel][4:0], cnt_sat);
		new_nbytes = 6'd1 << new_code;
		rd_adv_sum = {1'b0, rdoff_q[sel]} + (OW+1)'(new_nbytes);
		rd_adv     = (rd_adv_sum >= (OW+1)'(QUEUE_BYTES)) ?
			OW'(rd_adv_sum - (OW+1)'(QUEUE_BYTES)) : OW'(rd_adv_sum);
	end

	// byte fetch addressing
	always_comb begin
		b_nbytes  = 6'd1 << bcode_q;
		lanes     = (bcode_q >= CODE_WORD) ? LANES_WORD : b_nbytes[2:0];
		lane_last = ({1'b0, byte_cnt_q[1:0]} + 3'd1) == lanes;
		ring_sum  = {1'b0, boff_q} + (OW+1)'(byte_cnt_q);
		ring_idx  = (ring_sum >= (OW+1)'(QUEUE_BYTES)) ?
			OW'(ring_sum - (OW+1)'(QUEUE_BYTES)) : OW'(ring_sum);
		rd_addr   = MAW'(bq_q) * MAW'(QUEUE_BYTES) + MAW'(ring_idx);
	end

	// push addressing
	always_comb begin
		qi_hit     = 1'b0;
		wr_off_sel = '0;
		wr_cnt_sel = '0;
		for (int k = 0; k < NUM_QUEUES; k++) begin
			if (32'(queue_index) == k) begin
				qi_hit     = 1'b1;
				wr_off_sel = wroff_q[k];
				wr_cnt_sel = qcount_q[k];
			end
		end
		push_ok = ctrl.push && qi_hit && (wr_cnt_sel < CW'(QUEUE_BYTES));
		wr_addr = MAW'(queue_index) * MAW'(QUEUE_BYTES) + MAW'(wr_off_sel);
	end

	assign out_free = !out_valid_q || !out_stall;
	assign load_out = ctrl.put && word_full_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 1'b0;
			for (int k = 0; k < NUM_QUEUES; k++) begin
				qaddr_q[k]  <= '0;
				qcount_q[k] <= '0;
				rdoff_q[k]  <= '0;
				wroff_q[k]  <= '0;
				qon_q[k]    <= 1'b0;
				qwr_q[k]    <= 1'b0;
				qattr_q[k]  <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= array_configured;
			end
			for (int k = 0; k < NUM_QUEUES; k++) begin
				if (32'(queue_index) == k) begin
					if (ctrl.setup) begin
						qaddr_q[k]  <= start_address;
						qon_q[k]    <= queue_enable;
						qwr_q[k]    <= is_write;
						qattr_q[k]  <= attributes;
						qcount_q[k] <= '0;
						rdoff_q[k]  <= '0;
						wroff_q[k]  <= '0;
					end else if (push_ok) begin
						wroff_q[k]  <= (wroff_q[k] == OW'(QUEUE_BYTES - 1)) ?
							'0 : wroff_q[k] + OW'(1);
						qcount_q[k] <= qcount_q[k] + CW'(1);
					end
				end
			end
			if (ctrl.scan && found) begin
				qaddr_q[sel]  <= qaddr_q[sel] + 32'(new_nbytes);
				qcount_q[sel] <= qcount_q[sel] - CW'(new_nbytes);
				rdoff_q[sel]  <= rd_adv;
			end
		end
	end

	// byte ring memory
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_addr] <= data_byte;
		end
		if (ctrl.fetch) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			byte_cnt_q  <= '0;
			word_full_q <= 1'b0;
			word_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= ctrl.fetch;
			if (ctrl.scan) begin
				byte_cnt_q  <= '0;
				word_full_q <= !found;
				word_last_q <= !found;
			end else begin
				if (ctrl.fetch) begin
					byte_cnt_q <= byte_cnt_q + 6'd1;
					if (lane_last) begin
						word_last_q <= (byte_cnt_q + 6'd1) == b_nbytes;
					end
				end
				if (rd_vld_s1 && rd_fin_s1) begin
					word_full_q <= 1'b1;
				end else if (load_out) begin
					word_full_q <= 1'b0;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_lane_s1 <= byte_cnt_q[1:0];
		rd_fin_s1  <= lane_last;
		if (ctrl.scan) begin
			bvalid_q <= found;
			bq_q     <= found ? sel : '0;
			baddr_q  <= found ? qaddr_q[sel] : '0;
			bcode_q  <= found ? new_code : '0;
			battr_q  <= found ? qattr_q[sel] : '0;
			boff_q   <= rdoff_q[sel];
			word_q   <= '0;
		end else if (load_out) begin
			word_q <= '0;
		end else if (rd_vld_s1) begin
			word_q[{rd_lane_s1, 3'b000} +: 8] <= rd_data_s1;
		end
		if (load_out) begin
			o_req_valid_q <= bvalid_q;
			o_queue_q     <= 2'(bq_q);
			o_addr_q      <= baddr_q;
			o_code_q      <= bcode_q;
			o_attr_q      <= battr_q;
			o_data_q      <= word_q;
			// a drain without a request gives an all-zero result
			o_last_q      <= word_last_q && bvalid_q;
		end
	end

	assign status.found     = found;
	assign status.lane_last = lane_last;
	assign status.word_full = word_full_q;
	assign status.out_free  = out_free;
	assign status.word_last = word_last_q;

	assign out_valid          = out_valid_q;
	assign request_valid      = o_req_valid_q;
	assign served_queue       = o_queue_q;
	assign request_address    = o_addr_q;
	assign size_code          = o_code_q;
	assign request_attributes = o_attr_q;
	assign data_word          = o_data_q;
	assign last               = o_last_q;

endmodule

`default_nettype wire

[hw/rtl/write_queue_burst_drain.sv]
// top level of the write queue burst drain: controller and datapath
// set-up and push do not stall: the next transaction is taken in the following cycle
// drain: accept, scan, then per result word a fetch state reads its bytes (one byte
// per cycle through the single read port of the byte ring memory) and a put state
// waits for the word and a free output register; a drain with no request skips fetch;
// reset clears queue state, configuration and control; ring memory holds no reset
`timescale 1ns / 1ps
`default_nettype none

module write_queue_burst_drain #(
	parameter int NUM_QUEUES  = 4,
	parameter int QUEUE_BYTES = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire         array_configured,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  command,
	input  wire  [1:0]  queue_index,
	input  wire  [31:0] start_address,
	input  wire         queue_enable,
	input  wire         is_write,
	input  wire  [3:0]  attributes,
	input  wire  [7:0]  data_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        request_valid,
	output logic [1:0]  served_queue,
	output logic [31:0] request_address,
	output logic [2:0]  size_code,
	output logic [3:0]  request_attributes,
	output logic [31:0] data_word,
	output logic        last
);
	import wqbd_pkg::*;

	wqbd_ctrl_t   ctrl;
	wqbd_status_t status;

	wqbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.ctrl     (ctrl),
		.status   (status)
	);

	wqbd_dp #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_BYTES (QUEUE_BYTES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctrl               (ctrl),
		.status             (status),
		.cfg_wr_en          (cfg_wr_en),
		.array_configured   (array_configured),
		.queue_index        (queue_index),
		.start_address      (start_address),
		.queue_enable       (queue_enable),
		.is_write           (is_write),
		.attributes         (attributes),
		.data_byte          (data_byte),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.request_valid      (request_valid),
		.served_queue       (served_queue),
		.request_address    (request_address),
		.size_code          (size_code),
		.request_attributes (request_attributes),
		.data_word          (data_word),
		.last               (last)
	);

endmodule

`default_nettype wire

[hw/rtl/wqbd_checker.sv]
// port-level checks for the write queue burst drain, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module wqbd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire        request_valid,
	input wire [1:0]  served_queue,
	input wire [31:0] request_address,
	input wire [2:0]  size_code,
	input wire [3:0]  request_attributes,
	input wire [31:0] data_word,
	input wire        last
);

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_word) && $stable(last))
		else $error("stalled result changed");

	// drain without a request gives one all-zero result
	a_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !request_valid |-> !last && data_word == 32'd0 &&
			request_address == 32'd0 && size_code == 3'd0 && served_queue == 2'd0 &&
			request_attributes == 4'd0)
		else $error("empty drain result not zero");

	// byte and halfword bursts are a single result
	a_small_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_valid && size_code < 3'd2 |-> last)
		else $error("sub-word burst not marked last");

	// burst address aligned to its size
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_valid |->
			size_code <= 3'd5 &&
			(request_address & ((32'd1 << size_code) - 32'd1)) == 32'd0)
		else $error("burst misaligned");

endmodule

bind write_queue_burst_drain wqbd_checker u_wqbd_checker (.*);

`default_nettype wire
